### hw/rtl/cdf_pkg.sv
package cdf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Field position within the chunk, one-hot.
  typedef enum logic [3:0] {
    PH_LENGTH  = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic         valid;
    result_kind_t kind;
    logic [7:0]   payload;
    logic [31:0]  ctype;
    logic [31:0]  clen;
    logic         crc_ok;
  } cdf_result_t;

  // Reflected CRC-32 update over one byte, one shift per bit.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/cdf_core.sv
module cdf_core import cdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output cdf_result_t res
);

  phase_t      phase, phase_next, phase_eff;
  logic [31:0] byte_counter, byte_counter_next, cnt_eff;
  logic [31:0] length_reg, length_reg_next, len_eff;
  logic [31:0] type_reg, type_reg_next, type_eff;
  logic [31:0] running_crc, running_crc_next, crc_eff;
  logic [31:0] stored_crc, stored_crc_next, stored_eff;
  logic [32:0] cnt_inc;
  logic [31:0] stored_shift;

  always_comb begin
    // A restart drops the partial chunk before this byte is taken.
    phase_eff  = restart ? PH_LENGTH : phase;
    cnt_eff    = restart ? 32'd0 : byte_counter;
    len_eff    = restart ? 32'd0 : length_reg;
    type_eff   = restart ? 32'd0 : type_reg;
    crc_eff    = restart ? CRC_ONES : running_crc;
    stored_eff = restart ? 32'd0 : stored_crc;

    cnt_inc      = {1'b0, cnt_eff} + 33'd1;
    stored_shift = {stored_eff[23:0], data_byte};

    phase_next        = phase_eff;
    byte_counter_next = cnt_inc[31:0];
    length_reg_next   = len_eff;
    type_reg_next     = type_eff;
    running_crc_next  = crc_eff;
    stored_crc_next   = stored_eff;

    res         = '0;
    res.kind    = KIND_PAYLOAD;
    res.ctype   = type_eff;
    res.clen    = len_eff;

    case (phase_eff)
      PH_LENGTH: begin
        length_reg_next = {len_eff[23:0], data_byte};
        if (cnt_eff[1:0] == 2'd3) begin
          byte_counter_next = '0;
          phase_next        = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_reg_next    = {type_eff[23:0], data_byte};
        running_crc_next = crc32_byte(crc_eff, data_byte);
        if (cnt_eff[1:0] == 2'd3) begin
          byte_counter_next = '0;
          phase_next        = (len_eff == 32'd0) ? PH_CRC : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_crc_next = crc32_byte(crc_eff, data_byte);
        res.valid        = 1'b1;
        res.payload      = data_byte;
        if (cnt_inc >= {1'b0, len_eff}) begin
          byte_counter_next = '0;
          phase_next        = PH_CRC;
        end
      end
      PH_CRC: begin
        stored_crc_next = stored_shift;
        if (cnt_eff[1:0] == 2'd3) begin
          res.valid         = 1'b1;
          res.kind          = KIND_END;
          res.crc_ok        = (stored_shift == (crc_eff ^ CRC_ONES));
          phase_next        = PH_LENGTH;
          byte_counter_next = '0;
          length_reg_next   = '0;
          type_reg_next     = '0;
          running_crc_next  = CRC_ONES;
          stored_crc_next   = '0;
        end
      end
      default: begin
        phase_next = PH_LENGTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LENGTH;
      byte_counter <= '0;
      length_reg   <= '0;
      type_reg     <= '0;
      running_crc  <= CRC_ONES;
      stored_crc   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      length_reg   <= length_reg_next;
      type_reg     <= type_reg_next;
      running_crc  <= running_crc_next;
      stored_crc   <= stored_crc_next;
    end
  end

endmodule

### hw/rtl/chunk_deframer_crc_check.sv
// Chunk deframer with CRC-32 check. Feed the chunk stream one byte per
// transaction: 4-byte big-endian length, 4-byte big-endian type, payload,
// 4-byte big-endian CRC. Each payload byte comes out as a payload result;
// the last CRC byte yields one end-of-chunk result with type, length and
// crc_ok (reflected CRC-32 over type plus payload). Header bytes produce no
// result. Raise restart with a byte to drop any partial chunk; that byte is
// taken as the first length byte. The block sustains one byte per cycle
// while the result register is empty or draining, as the byte-wide CRC
// update between the input and result registers is combinational. A
// pending result in the output register does not stop intake as long as
// out_ready keeps draining it.
module chunk_deframer_crc_check import cdf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  input  logic         restart,
  output logic         out_valid,
  input  logic         out_ready,
  output result_kind_t result_kind,
  output logic [7:0]   payload_byte,
  output logic [31:0]  chunk_type,
  output logic [31:0]  chunk_length,
  output logic         crc_ok
);

  // Input register: one byte held for processing.
  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_restart;
  logic        advance;
  cdf_result_t res;

  // Advance the held byte when the result register is empty or draining.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload needs no reset; hold it until the next transaction.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte    <= data_byte;
      stage_restart <= restart;
    end
  end

  cdf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (stage_byte),
    .restart   (stage_restart),
    .res       (res)
  );

  // Result register: load on a producing byte, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      result_kind  <= res.kind;
      payload_byte <= res.payload;
      chunk_type   <= res.ctype;
      chunk_length <= res.clen;
      crc_ok       <= res.crc_ok;
    end
  end

endmodule

### hw/rtl/cdf_checker.sv
module cdf_checker import cdf_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input result_kind_t result_kind,
  input logic [7:0]   payload_byte,
  input logic         crc_ok
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(payload_byte)
      && $stable(crc_ok))
    else $error("result changed while stalled");

  // A payload result never carries a CRC verdict.
  a_payload_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |-> !crc_ok)
    else $error("crc_ok set on payload result");

  // An end-of-chunk result carries a zero payload byte.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_END |-> payload_byte == 8'd0)
    else $error("payload byte nonzero at chunk end");

  // A draining output never blocks intake.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind chunk_deframer_crc_check cdf_checker u_cdf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .payload_byte (payload_byte),
  .crc_ok       (crc_ok)
);
